// File: src/ocg_pkg.sv
package ocg_pkg;

    localparam int GRID_WIDTH  = 256;
    localparam int GRID_HEIGHT = 256;
    localparam int GRID_CELLS  = GRID_WIDTH * GRID_HEIGHT;
    localparam int ADDR_W      = $clog2(GRID_CELLS);
    localparam int DIM_W       = 13;
    localparam int COST_W      = 8;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 32;

    localparam logic [COST_W-1:0] COST_UNKNOWN = 8'd255;
    localparam logic [COST_W-1:0] COST_MAX     = 8'd254;

    typedef enum logic [1:0] {
        OP_MARK  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        REG_MAP_WIDTH      = 2'd0,
        REG_MAP_HEIGHT     = 2'd1,
        REG_COST_INCREMENT = 2'd2,
        REG_COST_DECREMENT = 2'd3
    } t_reg;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] cell_x;
        logic [7:0] cell_y;
        logic [7:0] robot_x;
        logic [7:0] robot_y;
    } t_in_item;

    typedef struct packed {
        logic [7:0] cell_cost;
        logic [7:0] cells_cleared;
        logic       in_bounds;
    } t_out_item;

    typedef struct packed {
        logic [8:0]        map_width;
        logic [8:0]        map_height;
        logic [COST_W-1:0] cost_increment;
        logic [COST_W-1:0] cost_decrement;
    } t_cfg;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [COST_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

    function automatic logic cell_inside(input logic [7:0] x, input logic [7:0] y,
                                         input t_cfg cfg);
        return (DIM_W'(x) < DIM_W'(cfg.map_width)) && (DIM_W'(y) < DIM_W'(cfg.map_height))
            && (DIM_W'(x) < DIM_W'(GRID_WIDTH)) && (DIM_W'(y) < DIM_W'(GRID_HEIGHT));
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [7:0] x, input logic [7:0] y);
        return ADDR_W'(ADDR_W'(y) * ADDR_W'(GRID_WIDTH)) + ADDR_W'(x);
    endfunction

    function automatic logic [7:0] step_toward(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] res;
        res = a;
        if (a < b) begin
            res = a + 8'd1;
        end else if (a > b) begin
            res = a - 8'd1;
        end
        return res;
    endfunction

    function automatic logic [COST_W-1:0] mark_cost(input logic [COST_W-1:0] now,
                                                    input logic [COST_W-1:0] inc);
        logic [COST_W-1:0] res;
        res = COST_MAX;
        if (now == COST_UNKNOWN) begin
            res = '0;
        end else if (inc < COST_MAX && now < COST_MAX - inc) begin
            res = now + inc;
        end
        return res;
    endfunction

    function automatic logic [COST_W-1:0] clear_cost(input logic [COST_W-1:0] now,
                                                     input logic [COST_W-1:0] dec);
        logic [COST_W-1:0] res;
        res = now - dec;
        if (now == COST_UNKNOWN || now < dec) begin
            res = '0;
        end
        return res;
    endfunction

endpackage

// File: src/occupancy_cost_grid_update.sv
// mark and read: cost memory read on the input transfer, mark written in S_LOOK, result loaded from S_RESULT
// clear of n ray steps (n up to 255): S_WALK steps cell by cell toward the robot, then S_RESULT
// the ray walk does one read-modify-write of the cost memory per cell, pipelined
// hit cell outside the map or unused operation: straight to S_RESULT; an output stall holds S_RESULT
// reset: registers to defaults, then a pass zeroes every cost memory cell; input stalled outside S_IDLE
module occupancy_cost_grid_update (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ocg_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ocg_pkg::t_out_item            o_out_item,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ocg_pkg::PADDR_W-1:0]   paddr,
    input  logic [ocg_pkg::PDATA_W-1:0]   pwdata,
    output logic [ocg_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    import ocg_pkg::*;

    t_cfg              cfg;
    t_ram_req          ram_req;
    logic [COST_W-1:0] rd_data;

    ocg_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ocg_ram #(
        .WIDTH (COST_W),
        .DEPTH (GRID_CELLS)
    ) u_cost_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_req.wr_en),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_rd_en   (ram_req.rd_en),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (rd_data)
    );

    ocg_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_ram       (ram_req),
        .i_rd_data   (rd_data)
    );

endmodule

// File: src/ocg_ram.sv
module ocg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/ocg_cfg_regs.sv
module ocg_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ocg_pkg::PADDR_W-1:0]   paddr,
    input  logic [ocg_pkg::PDATA_W-1:0]   pwdata,
    output logic [ocg_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output ocg_pkg::t_cfg                 o_cfg
);

    import ocg_pkg::*;

    t_cfg r_cfg;
    t_reg reg_sel;

    assign reg_sel = t_reg'(paddr[3:2]);
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.map_width      <= 9'd256;
            r_cfg.map_height     <= 9'd256;
            r_cfg.cost_increment <= 8'd10;
            r_cfg.cost_decrement <= 8'd10;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_MAP_WIDTH:      r_cfg.map_width      <= pwdata[8:0];
                REG_MAP_HEIGHT:     r_cfg.map_height     <= pwdata[8:0];
                REG_COST_INCREMENT: r_cfg.cost_increment <= pwdata[7:0];
                REG_COST_DECREMENT: r_cfg.cost_decrement <= pwdata[7:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_MAP_WIDTH:      prdata = PDATA_W'(r_cfg.map_width);
            REG_MAP_HEIGHT:     prdata = PDATA_W'(r_cfg.map_height);
            REG_COST_INCREMENT: prdata = PDATA_W'(r_cfg.cost_increment);
            REG_COST_DECREMENT: prdata = PDATA_W'(r_cfg.cost_decrement);
        endcase
    end

endmodule

// File: src/ocg_engine.sv
module ocg_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ocg_pkg::t_cfg                  i_cfg,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  ocg_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output ocg_pkg::t_out_item             o_out_item,
    output ocg_pkg::t_ram_req              o_ram,
    input  logic [ocg_pkg::COST_W-1:0]     i_rd_data
);

    import ocg_pkg::*;

    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_LOOK   = 5'b00100,
        S_WALK   = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(GRID_CELLS - 1);

    t_state            r_state,     n_state;
    logic [ADDR_W-1:0] r_init_addr, n_init_addr;
    t_in_item          r_item,      n_item;
    logic [7:0]        r_x,         n_x;
    logic [7:0]        r_y,         n_y;
    logic              r_pend_valid, n_pend_valid;
    logic [ADDR_W-1:0] r_pend_addr, n_pend_addr;
    logic [COST_W-1:0] r_cost,      n_cost;
    logic [7:0]        r_count,     n_count;
    logic              r_inb,       n_inb;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_item,  n_out_item;
    t_ram_req          ram_req;

    logic              hit_inside;
    logic [7:0]        step_x;
    logic [7:0]        step_y;
    logic              step_inside;
    logic              walk_done;
    logic [COST_W-1:0] marked;

    assign hit_inside  = cell_inside(i_in_item.cell_x, i_in_item.cell_y, i_cfg);
    assign step_x      = step_toward(r_x, r_item.robot_x);
    assign step_y      = step_toward(r_y, r_item.robot_y);
    assign step_inside = cell_inside(step_x, step_y, i_cfg);
    assign walk_done   = (r_x == r_item.robot_x) && (r_y == r_item.robot_y);
    assign marked      = mark_cost(i_rd_data, i_cfg.cost_increment);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign o_ram       = ram_req;

    always_comb begin
        n_state      = r_state;
        n_init_addr  = r_init_addr;
        n_item       = r_item;
        n_x          = r_x;
        n_y          = r_y;
        n_pend_valid = 1'b0;
        n_pend_addr  = r_pend_addr;
        n_cost       = r_cost;
        n_count      = r_count;
        n_inb        = r_inb;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_item   = r_out_item;
        ram_req      = '0;

        // write back the cell read in the previous walk cycle
        if (r_pend_valid) begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = r_pend_addr;
            ram_req.wr_data = clear_cost(i_rd_data, i_cfg.cost_decrement);
            n_count         = r_count + 8'd1;
        end

        unique case (r_state)
            S_INIT: begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = r_init_addr;
                ram_req.wr_data = '0;
                n_init_addr     = r_init_addr + ADDR_W'(1);
                if (r_init_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_x     = i_in_item.cell_x;
                    n_y     = i_in_item.cell_y;
                    n_cost  = '0;
                    n_count = '0;
                    n_inb   = 1'b0;
                    n_state = S_RESULT;
                    priority if (i_in_item.operation == OP_MARK
                                 || i_in_item.operation == OP_READ) begin
                        n_inb = hit_inside;
                        if (hit_inside) begin
                            ram_req.rd_en   = 1'b1;
                            ram_req.rd_addr = cell_addr(i_in_item.cell_x, i_in_item.cell_y);
                            n_state         = S_LOOK;
                        end
                    end else if (i_in_item.operation == OP_CLEAR) begin
                        n_inb = hit_inside;
                        if (hit_inside) begin
                            n_state = S_WALK;
                        end
                    end else begin
                        n_inb = 1'b0;
                    end
                end
            end
            S_LOOK: begin
                n_cost = i_rd_data;
                if (r_item.operation == OP_MARK) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = cell_addr(r_item.cell_x, r_item.cell_y);
                    ram_req.wr_data = marked;
                    n_cost          = marked;
                end
                n_state = S_RESULT;
            end
            S_WALK: begin
                if (walk_done) begin
                    n_state = S_RESULT;
                end else begin
                    n_x = step_x;
                    n_y = step_y;
                    if (step_inside) begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = cell_addr(step_x, step_y);
                        n_pend_valid    = 1'b1;
                        n_pend_addr     = cell_addr(step_x, step_y);
                    end
                end
            end
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid              = 1'b1;
                    n_out_item.cell_cost     = r_cost;
                    n_out_item.cells_cleared = r_count;
                    n_out_item.in_bounds     = r_inb;
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_init_addr  <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_init_addr  <= n_init_addr;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item      <= n_item;
        r_x         <= n_x;
        r_y         <= n_y;
        r_pend_addr <= n_pend_addr;
        r_cost      <= n_cost;
        r_count     <= n_count;
        r_inb       <= n_inb;
        r_out_item  <= n_out_item;
    end

    a_no_same_cell_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_req.rd_en && ram_req.wr_en) |-> (ram_req.rd_addr != ram_req.wr_addr))
        else $error("read and write to the same cell in one cycle");

    a_pend_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> $past(ram_req.rd_en))
        else $error("write back without a preceding read");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !ram_req.wr_en)
        else $error("cost memory written while idle");

    a_cleared_in_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_item.cells_cleared != 8'd0) |-> r_out_item.in_bounds)
        else $error("cells cleared reported for a hit cell outside the map");

    a_walk_ends_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESULT) |-> !r_pend_valid)
        else $error("result taken with a write back outstanding");

endmodule

// File: tb/tb_occupancy_cost_grid_update.sv
`timescale 1ns / 100ps

module tb_occupancy_cost_grid_update;

    import ocg_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int CLK_HALF_NS         = 6;
    localparam int RESET_CYCLES        = 4;
    localparam int PHASE_COUNT         = 8;
    localparam int PHASE_ITEMS         = 190;
    localparam int SETTLE_CYCLES       = 4;
    localparam int TAIL_CYCLES         = 300;
    localparam int WATCHDOG_NS         = 48_000_000;

    typedef struct {
        bit          is_cfg;
        t_reg        cfg_reg;
        logic [31:0] cfg_value;
        t_in_item    item;
        bit          typed;
        t_out_item   want;
    } t_row;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    t_in_item            in_item;
    logic                out_valid;
    logic                out_stall = 1'b0;
    t_out_item           out_item;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    logic [COST_W-1:0]   cost_grid_model [0:GRID_CELLS-1];
    logic [8:0]          cfg_width;
    logic [8:0]          cfg_height;
    logic [COST_W-1:0]   cfg_inc;
    logic [COST_W-1:0]   cfg_dec;

    t_out_item           pending_results [$];
    t_row                script [$];
    int                  fail_count = 0;
    int                  stall_mode = 0;
    int                  stall_mode_cnt = 0;

    occupancy_cost_grid_update dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        clk = 1'b0;
        #(CLK_HALF_NS);
        clk = 1'b1;
        #(CLK_HALF_NS);
    end

    initial begin
        #(WATCHDOG_NS);
        $display("simulation failed");
        $finish;
    end

    // receiver back-pressure: free, coin-flip or mostly stalled stretches
    always @(negedge clk) begin
        if (stall_mode_cnt == 0) begin
            stall_mode     <= $urandom_range(0, 2);
            stall_mode_cnt <= $urandom_range(20, 200);
        end else begin
            stall_mode_cnt <= stall_mode_cnt - 1;
        end
        case (stall_mode)
            0: begin
                out_stall <= 1'b0;
            end
            1: begin
                out_stall <= ($urandom_range(0, 1) == 1);
            end
            default: begin
                out_stall <= ($urandom_range(0, 7) != 0);
            end
        endcase
    end

    function automatic bit cell_on_map(input logic [7:0] x, input logic [7:0] y);
        return int'(x) < int'(cfg_width) && int'(y) < int'(cfg_height)
            && int'(x) < GRID_WIDTH && int'(y) < GRID_HEIGHT;
    endfunction

    function automatic t_out_item predict_grid_update(input t_in_item it);
        t_out_item         res;
        logic [7:0]        x;
        logic [7:0]        y;
        logic [COST_W-1:0] now;
        int                idx;
        res = '0;
        case (it.operation)
            OP_MARK, OP_READ: begin
                if (cell_on_map(it.cell_x, it.cell_y)) begin
                    idx = int'(it.cell_y) * GRID_WIDTH + int'(it.cell_x);
                    now = cost_grid_model[idx];
                    res.in_bounds = 1'b1;
                    if (it.operation == OP_MARK) begin
                        if (now == COST_UNKNOWN) begin
                            now = '0;
                        end else if (int'(now) + int'(cfg_inc) < int'(COST_MAX)) begin
                            now = now + cfg_inc;
                        end else begin
                            now = COST_MAX;
                        end
                        cost_grid_model[idx] = now;
                    end
                    res.cell_cost = now;
                end
            end
            OP_CLEAR: begin
                if (cell_on_map(it.cell_x, it.cell_y)) begin
                    res.in_bounds = 1'b1;
                    x = it.cell_x;
                    y = it.cell_y;
                    while (x != it.robot_x || y != it.robot_y) begin
                        if (x < it.robot_x) begin
                            x = x + 8'd1;
                        end else if (x > it.robot_x) begin
                            x = x - 8'd1;
                        end
                        if (y < it.robot_y) begin
                            y = y + 8'd1;
                        end else if (y > it.robot_y) begin
                            y = y - 8'd1;
                        end
                        if (cell_on_map(x, y)) begin
                            idx = int'(y) * GRID_WIDTH + int'(x);
                            now = cost_grid_model[idx];
                            if (now == COST_UNKNOWN || now < cfg_dec) begin
                                now = '0;
                            end else begin
                                now = now - cfg_dec;
                            end
                            cost_grid_model[idx] = now;
                            res.cells_cleared = res.cells_cleared + 8'd1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing pending: %s %0d %0d %0d",
                       "cell_cost cells_cleared in_bounds",
                       out_item.cell_cost, out_item.cells_cleared, out_item.in_bounds);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_item.cell_cost !== want.cell_cost) begin
                    $error("cell_cost: expected %0d, got %0d", want.cell_cost, out_item.cell_cost);
                    fail_count++;
                end
                if (out_item.cells_cleared !== want.cells_cleared) begin
                    $error("cells_cleared: expected %0d, got %0d",
                           want.cells_cleared, out_item.cells_cleared);
                    fail_count++;
                end
                if (out_item.in_bounds !== want.in_bounds) begin
                    $error("in_bounds: expected %0d, got %0d", want.in_bounds, out_item.in_bounds);
                    fail_count++;
                end
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item predicted;
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall !== 1'b0) begin
            @(posedge clk);
        end
        predicted = predict_grid_update(it);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
        @(negedge clk);
    endtask

    task automatic wait_drain();
        while (pending_results.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // write transfer followed straight away by a read-back transfer
    task automatic cfg_write(input t_reg sel, input logic [31:0] value);
        logic [31:0] mask;
        mask = (sel == REG_MAP_WIDTH || sel == REG_MAP_HEIGHT) ? 32'h1ff : 32'hff;
        paddr   <= PADDR_W'({sel, 2'b00});
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) begin
            @(posedge clk);
        end
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1) begin
            @(posedge clk);
        end
        if ((prdata & mask) !== (value & mask)) begin
            $error("register %s: expected %0d, got %0d", sel.name(), value & mask, prdata & mask);
            fail_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (sel)
            REG_MAP_WIDTH:      cfg_width  = value[8:0];
            REG_MAP_HEIGHT:     cfg_height = value[8:0];
            REG_COST_INCREMENT: cfg_inc    = value[7:0];
            default:            cfg_dec    = value[7:0];
        endcase
    endtask

    function automatic t_row item_row(input logic [1:0] op, input int cx, cy, rx, ry,
                                      input int typed, input int cost, clr, inb);
        t_row r;
        r.is_cfg    = 1'b0;
        r.cfg_reg   = REG_MAP_WIDTH;
        r.cfg_value = '0;
        r.item      = '{op, 8'(cx), 8'(cy), 8'(rx), 8'(ry)};
        r.typed     = (typed != 0);
        r.want      = '{8'(cost), 8'(clr), 1'(inb)};
        return r;
    endfunction

    function automatic t_row cfg_row(input t_reg sel, input logic [31:0] value);
        t_row r;
        r.is_cfg    = 1'b1;
        r.cfg_reg   = sel;
        r.cfg_value = value;
        r.item      = '0;
        r.typed     = 1'b0;
        r.want      = '0;
        return r;
    endfunction

    function automatic void add_row(input t_row r);
        script.insert(script.size(), r);
    endfunction

    function automatic logic [7:0] pick_coord(input int limit, input logic [7:0] focus);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return focus + 8'($urandom_range(0, 3));
        end
        if (r < 8) begin
            return 8'($urandom_range(0, limit - 1));
        end
        return 8'($urandom);
    endfunction

    initial begin
        t_in_item   it;
        logic [8:0] w;
        logic [8:0] h;
        logic [7:0] inc_v;
        logic [7:0] dec_v;
        logic [7:0] fx;
        logic [7:0] fy;
        int         eff_w;
        int         eff_h;
        int         r;
        int         burst_left;
        bit         gapless;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_item  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        for (int i = 0; i < GRID_CELLS; i++) begin
            cost_grid_model[i] = '0;
        end
        cfg_width  = 9'd256;
        cfg_height = 9'd256;
        cfg_inc    = 8'd10;
        cfg_dec    = 8'd10;

        // directed rows, reset defaults first
        add_row(item_row(OP_READ,    0,   0,   0,   0, 1, 0, 0, 1));
        add_row(item_row(OP_READ,  255, 255, 255, 255, 1, 0, 0, 1));
        add_row(item_row(OP_MARK,    0,   0,  90,  40, 1, 10, 0, 1));
        add_row(item_row(OP_MARK,  255, 255,   0,   0, 1, 10, 0, 1));
        add_row(item_row(OP_MARK,  255, 255, 255, 255, 1, 20, 0, 1));
        add_row(item_row(OP_MARK,    0, 255,  17, 200, 1, 10, 0, 1));
        add_row(item_row(OP_MARK,  255,   0, 128,  64, 1, 10, 0, 1));
        add_row(item_row(OP_CLEAR, 255, 255, 255, 255, 1, 0, 0, 1));
        add_row(item_row(OP_CLEAR,   0,   0, 255, 255, 1, 0, 255, 1));
        add_row(item_row(OP_READ,  255, 255,   3,   3, 1, 10, 0, 1));
        add_row(item_row(OP_CLEAR, 255,   0,   0, 255, 1, 0, 255, 1));
        add_row(item_row(OP_CLEAR,   0, 255,   0,   0, 1, 0, 255, 1));
        add_row(item_row(OP_UNUSED, 12,  34, 200,   7, 1, 0, 0, 0));
        add_row(item_row(OP_READ,    0,   0,   0,   0, 0, 0, 0, 0));
        add_row(cfg_row(REG_MAP_WIDTH, 16));
        add_row(cfg_row(REG_MAP_HEIGHT, 8));
        add_row(item_row(OP_MARK,   16,   0,   0,   0, 1, 0, 0, 0));
        add_row(item_row(OP_READ,    3,   8,   0,   0, 1, 0, 0, 0));
        add_row(item_row(OP_MARK,   15,   7,   1,   1, 0, 0, 0, 0));
        add_row(item_row(OP_CLEAR,  20,   3,   5,   3, 1, 0, 0, 0));
        add_row(item_row(OP_CLEAR,  10,   2, 200, 100, 0, 0, 0, 0));
        add_row(cfg_row(REG_COST_INCREMENT, 255));
        add_row(item_row(OP_MARK,   15,   7,   0,   0, 1, 254, 0, 1));
        add_row(cfg_row(REG_COST_DECREMENT, 255));
        add_row(item_row(OP_CLEAR,  15,   0,  15,   7, 1, 0, 7, 1));
        add_row(item_row(OP_READ,   15,   7,   0,   0, 1, 0, 0, 1));
        add_row(cfg_row(REG_MAP_WIDTH, 0));
        add_row(item_row(OP_READ,    0,   0,   0,   0, 1, 0, 0, 0));
        add_row(cfg_row(REG_MAP_WIDTH, 511));
        add_row(cfg_row(REG_MAP_HEIGHT, 511));
        add_row(item_row(OP_MARK,  255, 255,   9,   9, 1, 254, 0, 1));
        add_row(cfg_row(REG_COST_INCREMENT, 0));
        add_row(item_row(OP_MARK,  255, 255,   9,   9, 1, 254, 0, 1));

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                in_valid <= 1'b0;
                wait_drain();
                cfg_write(script[i].cfg_reg, script[i].cfg_value);
            end else begin
                send_item(script[i].item, script[i].typed, script[i].want);
            end
        end

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin
                    w = 9'd256; h = 9'd256; inc_v = 8'd10;  dec_v = 8'd10;
                end
                1: begin
                    w = 9'd1;   h = 9'd1;   inc_v = 8'd0;   dec_v = 8'd0;
                end
                2: begin
                    w = 9'd511; h = 9'd511; inc_v = 8'd255; dec_v = 8'd255;
                end
                3: begin
                    w = 9'd300; h = 9'd40;  inc_v = 8'd254; dec_v = 8'd0;
                end
                4: begin
                    w = 9'd33;  h = 9'd256; inc_v = 8'd1;   dec_v = 8'd3;
                end
                default: begin
                    w     = 9'($urandom_range(1, 300));
                    h     = 9'($urandom_range(1, 300));
                    inc_v = 8'($urandom_range(0, 255));
                    dec_v = 8'($urandom_range(0, 255));
                end
            endcase
            in_valid <= 1'b0;
            wait_drain();
            cfg_write(REG_MAP_WIDTH, 32'(w));
            cfg_write(REG_MAP_HEIGHT, 32'(h));
            cfg_write(REG_COST_INCREMENT, 32'(inc_v));
            cfg_write(REG_COST_DECREMENT, 32'(dec_v));

            eff_w      = (w > 256) ? 256 : int'(w);
            eff_h      = (h > 256) ? 256 : int'(h);
            fx         = 8'($urandom_range(0, eff_w - 1));
            fy         = 8'($urandom_range(0, eff_h - 1));
            gapless    = (p % 3 == 0);
            burst_left = $urandom_range(1, 20);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (!gapless && burst_left == 0) begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 10)) @(negedge clk);
                    burst_left = $urandom_range(1, 20);
                end
                if ($urandom_range(0, 99) == 0) begin
                    in_valid <= 1'b0;
                    wait_drain();
                end
                r = $urandom_range(0, 19);
                if (r < 9) begin
                    it.operation = OP_MARK;
                end else if (r < 15) begin
                    it.operation = OP_CLEAR;
                end else if (r < 19) begin
                    it.operation = OP_READ;
                end else begin
                    it.operation = OP_UNUSED;
                end
                it.cell_x = pick_coord(eff_w, fx);
                it.cell_y = pick_coord(eff_h, fy);
                if ($urandom_range(0, 9) < 6) begin
                    it.robot_x = it.cell_x + 8'($urandom_range(0, 12)) - 8'd6;
                    it.robot_y = it.cell_y + 8'($urandom_range(0, 12)) - 8'd6;
                end else begin
                    it.robot_x = 8'($urandom);
                    it.robot_y = 8'($urandom);
                end
                send_item(it, 1'b0, '0);
                if (burst_left > 0) begin
                    burst_left--;
                end
            end
        end

        in_valid <= 1'b0;
        wait_drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
src/ocg_pkg.sv
src/ocg_ram.sv
src/ocg_cfg_regs.sv
src/ocg_engine.sv
src/occupancy_cost_grid_update.sv
tb/tb_occupancy_cost_grid_update.sv
